// ===== design/windowed_event_rate_counter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the windowed event rate counter
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_EVENT_RATE_COUNTER_ASSERT_SVH
`define WINDOWED_EVENT_RATE_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WERC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WERC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/werc_pkg.sv =====
// ----------------------------------------------------------------------------
// werc_pkg
// Widths, codes and defaults shared by the windowed event rate counter.
// ----------------------------------------------------------------------------
`default_nettype none

package werc_pkg;

	localparam int BUCKETS_DEF = 60;
	localparam int QUEUE_DEPTH = 4;

	localparam int KIND_W  = 2;
	localparam int NOW_W   = 32;
	localparam int CNT_W   = 32;
	localparam int TOTAL_W = 64;
	localparam int WIN_W   = 38;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_USED_W = 2 * TOTAL_W + WIN_W;
	localparam int OUT_DATA_W = 168;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [WIN_W-1:0] WIN_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_EVENT = 2'd0,
		KIND_FLUSH = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

endpackage

`default_nettype wire

// ===== design/werc_front.sv =====
// ----------------------------------------------------------------------------
// werc_front
// Accepts items, drops unused kinds and works out the bucket index.
// ----------------------------------------------------------------------------
`default_nettype none

module werc_front import werc_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	localparam int IDX_W = $clog2(BUCKETS),
	localparam int ITEM_W = KIND_W + NOW_W + IDX_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [NOW_W-1:0]  s_tdata,
	input  wire logic [KIND_W-1:0] s_tuser,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output logic [ITEM_W-1:0]      q_data
);

	localparam int REM_W = IDX_W + 1;
	localparam logic [NOW_W-1:0] RECIP = NOW_W'((64'd1 << NOW_W) / BUCKETS);
	localparam logic [REM_W-1:0] B_REM = REM_W'(BUCKETS);

	logic                   move;
	logic                   kind_ok;
	logic [2*NOW_W-1:0]     prod;
	logic                   v_s1;
	logic                   v_s2;
	logic [KIND_W-1:0]      kind_s1;
	logic [KIND_W-1:0]      kind_s2;
	logic [NOW_W-1:0]       now_s1;
	logic [NOW_W-1:0]       now_s2;
	logic [NOW_W-1:0]       quot_s1;
	logic [REM_W-1:0]       qb_s2;
	logic [REM_W-1:0]       rem;
	logic [IDX_W-1:0]       idx;

	assign move     = !v_s2 || q_ready;
	assign s_tready = move;
	assign kind_ok  = (s_tuser == KIND_EVENT) || (s_tuser == KIND_FLUSH) ||
		(s_tuser == KIND_QUERY);

	// The quotient estimate is low by at most one, so the remainder below
	// needs a single conditional subtract.
	assign prod = {{NOW_W{1'b0}}, s_tdata} * {{NOW_W{1'b0}}, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (move) begin
			v_s1 <= s_tvalid && kind_ok;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			kind_s1 <= s_tuser;
			now_s1  <= s_tdata;
			quot_s1 <= prod[2*NOW_W-1:NOW_W];
			kind_s2 <= kind_s1;
			now_s2  <= now_s1;
			qb_s2   <= REM_W'(quot_s1[REM_W-1:0] * B_REM);
		end
	end

	assign rem = now_s2[REM_W-1:0] - qb_s2;
	assign idx = (rem >= B_REM) ? IDX_W'(rem - B_REM) : rem[IDX_W-1:0];

	assign q_valid = v_s2;
	assign q_data  = {idx, now_s2, kind_s2};

endmodule

`default_nettype wire

// ===== design/werc_fifo.sv =====
// ----------------------------------------------------------------------------
// werc_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module werc_fifo import werc_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [DATA_W-1:0] in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [DATA_W-1:0]      out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(DEPTH);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != CNT_FULL);
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

`default_nettype wire

// ===== design/werc_back.sv =====
// ----------------------------------------------------------------------------
// werc_back
// Bucket memory, running totals, window walk and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module werc_back import werc_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	localparam int IDX_W = $clog2(BUCKETS),
	localparam int ITEM_W = KIND_W + NOW_W + IDX_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  wire logic [ITEM_W-1:0] q_data,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata
);

	localparam int ACC_W = (NOW_W + IDX_W > WIN_W) ? NOW_W + IDX_W : WIN_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUCKETS - 1);
	localparam logic [NOW_W-1:0] SPAN = NOW_W'(BUCKETS);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_EV_UPD  = 4'b0010,
		ST_Q_ISSUE = 4'b0100,
		ST_Q_WAIT  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [NOW_W+CNT_W-1:0]   bucket_mem [BUCKETS];
	logic [NOW_W+CNT_W-1:0]   rdata_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic [IDX_W-1:0]         rd_addr;
	logic [BUCKETS-1:0]       valid_q;
	logic [TOTAL_W-1:0]       ev_total_q;
	logic [TOTAL_W-1:0]       fl_total_q;
	logic [NOW_W-1:0]         now_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         ptr_q;
	logic                     rd_act_q;
	logic                     rd_last_q;
	logic                     term_vld_q;
	logic                     term_last_q;
	logic [CNT_W-1:0]         term_q;
	logic [ACC_W-1:0]         acc_q;
	logic [ACC_W-1:0]         sum_next;
	logic [WIN_W-1:0]         win_sat;
	logic                     out_valid_q;
	logic [TOTAL_W-1:0]       out_ev_q;
	logic [TOTAL_W-1:0]       out_fl_q;
	logic [WIN_W-1:0]         out_win_q;

	logic [KIND_W-1:0]        head_kind;
	logic [NOW_W-1:0]         head_now;
	logic [IDX_W-1:0]         head_idx;
	logic                     is_idle;
	logic                     pop_event;
	logic                     pop_flush;
	logic                     pop_query;
	logic                     mem_we;
	logic [NOW_W-1:0]         old_tag;
	logic [CNT_W-1:0]         old_cnt;
	logic                     hit;
	logic [CNT_W-1:0]         new_cnt;
	logic [NOW_W-1:0]         rd_tag;
	logic                     in_window;

	assign head_kind = q_data[KIND_W-1:0];
	assign head_now  = q_data[KIND_W +: NOW_W];
	assign head_idx  = q_data[KIND_W+NOW_W +: IDX_W];

	assign is_idle   = (state_q == ST_IDLE);
	assign pop_event = is_idle && q_valid && (head_kind == KIND_EVENT);
	assign pop_flush = is_idle && q_valid && (head_kind == KIND_FLUSH);
	assign pop_query = is_idle && q_valid && (head_kind == KIND_QUERY) && !out_valid_q;
	assign q_ready   = pop_event || pop_flush || pop_query;

	assign rd_addr = (state_q == ST_Q_ISSUE) ? ptr_q : head_idx;
	assign mem_we  = (state_q == ST_EV_UPD);

	// A bucket not written since reset is known by its clear valid bit.
	assign old_tag = rdata_q[CNT_W +: NOW_W];
	assign old_cnt = rdata_q[CNT_W-1:0];
	assign hit     = valid_q[idx_q] && (old_tag == now_q);
	assign new_cnt = hit ? ((old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1) : CNT_W'(1);

	assign rd_tag    = rdata_q[CNT_W +: NOW_W];
	assign in_window = valid_q[rd_idx_q] && (rd_tag <= now_q) && ((now_q - rd_tag) < SPAN);

	assign sum_next = acc_q + ACC_W'(term_q);
	assign win_sat  = (sum_next > ACC_W'(WIN_MAX)) ? WIN_MAX : sum_next[WIN_W-1:0];

	always_ff @(posedge clk) begin
		rdata_q  <= bucket_mem[rd_addr];
		rd_idx_q <= rd_addr;
		if (mem_we) begin
			bucket_mem[idx_q] <= {now_q, new_cnt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			ev_total_q  <= '0;
			fl_total_q  <= '0;
			ptr_q       <= '0;
			rd_act_q    <= 1'b0;
			rd_last_q   <= 1'b0;
			term_vld_q  <= 1'b0;
			term_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_act_q    <= (state_q == ST_Q_ISSUE);
			rd_last_q   <= (state_q == ST_Q_ISSUE) && (ptr_q == IDX_LAST);
			term_vld_q  <= rd_act_q;
			term_last_q <= rd_last_q;
			if (pop_event) begin
				ev_total_q <= ev_total_q + 1'b1;
			end
			if (pop_flush) begin
				fl_total_q <= fl_total_q + 1'b1;
			end
			if (mem_we) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (term_last_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_event) begin
						state_q <= ST_EV_UPD;
					end else if (pop_query) begin
						ptr_q   <= '0;
						state_q <= ST_Q_ISSUE;
					end
				end
				ST_EV_UPD: begin
					state_q <= ST_IDLE;
				end
				ST_Q_ISSUE: begin
					if (ptr_q == IDX_LAST) begin
						state_q <= ST_Q_WAIT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_Q_WAIT: begin
					if (term_last_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_event || pop_query) begin
			now_q <= head_now;
			idx_q <= head_idx;
		end
		term_q <= in_window ? rdata_q[CNT_W-1:0] : '0;
		if (pop_query) begin
			acc_q <= '0;
		end else if (term_vld_q) begin
			acc_q <= sum_next;
		end
		if (term_last_q) begin
			out_ev_q  <= ev_total_q;
			out_fl_q  <= fl_total_q;
			out_win_q <= win_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_win_q, out_fl_q, out_ev_q};

endmodule

`default_nettype wire

// ===== design/windowed_event_rate_counter.sv =====
// ----------------------------------------------------------------------------
// windowed_event_rate_counter
// Per-second event buckets over a sliding window, with running totals.
// ----------------------------------------------------------------------------
// The input side takes one item per cycle into a two-stage index pipeline
// and a four-entry queue, so it stalls only when that queue is full. The back
// end, which owns the bucket memory (one read port, one write port), takes a
// flush without leaving its idle state, handles an event as a memory read and
// then a write back, and on a query walks the memory one bucket per cycle; a
// query also waits until the previous result has been taken. Buckets carry
// valid bits, so the block is ready straight out of reset with no clearing pass.
`default_nettype none

module windowed_event_rate_counter import werc_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // now_second[31:0]
	input  wire logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata    // total_events[63:0],
	                                              // total_flushes[127:64],
	                                              // window_events[165:128]
);

	localparam int IDX_W = $clog2(BUCKETS);
	localparam int ITEM_W = KIND_W + NOW_W + IDX_W;

	logic              fr_valid;
	logic              fr_ready;
	logic [ITEM_W-1:0] fr_data;
	logic              bk_valid;
	logic              bk_ready;
	logic [ITEM_W-1:0] bk_data;

	werc_front #(
		.BUCKETS(BUCKETS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (fr_valid),
		.q_ready (fr_ready),
		.q_data  (fr_data)
	);

	werc_fifo #(
		.DATA_W(ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.in_data  (fr_data),
		.out_valid(bk_valid),
		.out_ready(bk_ready),
		.out_data (bk_data)
	);

	werc_back #(
		.BUCKETS(BUCKETS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (bk_valid),
		.q_ready (bk_ready),
		.q_data  (bk_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire

// ===== design/werc_checker.sv =====
// ----------------------------------------------------------------------------
// werc_checker
// Port-level checks on the result stream of the rate counter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_event_rate_counter_assert.svh"

module werc_checker import werc_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	`WERC_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

	`WERC_ASSERT_IMP(a_win_le_total, clk, arst_n, m_tvalid, m_tdata[2*TOTAL_W +: WIN_W] <= m_tdata[TOTAL_W-1:0], "window sum exceeds total events")

	`WERC_ASSERT_IMP(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[OUT_DATA_W-1:OUT_USED_W] == '0, "padding bits of a result are not zero")

	`WERC_ASSERT_IMP(a_quiet_after_reset, clk, arst_n, !$past(arst_n), !m_tvalid, "result shown right after reset")

endmodule

bind windowed_event_rate_counter werc_checker u_werc_checker (.*);

`default_nettype wire

// ===== test/tb_windowed_event_rate_counter.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_event_rate_counter
// Self-checking bench for the windowed event rate counter. A queue of event,
// flush, query and unused-kind items is played into the input stream with
// random gaps. A transaction-level predictor keeps its own buckets and totals, and
// every query result is checked field by field against it, in order. The
// receiver stalls at random and twice holds off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_windowed_event_rate_counter;
	import werc_pkg::*;

	localparam int NUM_BUCKETS = BUCKETS_DEF;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1750;
	localparam int PHASE_ITEMS = 250;
	localparam int CYCLE_LIMIT = 1200000;
	localparam int TAIL_CYCLES = 2 * NUM_BUCKETS + 20;
	localparam int LONG_HOLD = 600;
	localparam int HOLD_START_A = 2000;
	localparam int HOLD_START_B = 15000;
	localparam int QUIET_PERIOD = 400;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NOW_W-1:0]  now_second;
		logic              wait_drain;
	} rate_item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_events;
		logic [TOTAL_W-1:0] total_flushes;
		logic [WIN_W-1:0]   window_events;
	} rate_stats_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // now_second[31:0]
	logic [KIND_W-1:0]     s_tuser = '0;   // kind[1:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // total_events[63:0], total_flushes[127:64],
	                                       // window_events[165:128]

	rate_item_t  item_queue[$];
	rate_stats_t stats_expected[$];
	rate_item_t  cur_item;
	logic        tx_busy = 1'b0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          hold_left = 0;
	logic        quiet_mode = 1'b0;
	int          cycle_count = 0;
	logic        timed_out = 1'b0;

	logic [TOTAL_W-1:0] event_count_q;
	logic [TOTAL_W-1:0] flush_count_q;
	logic [NOW_W-1:0]   tag_mem[NUM_BUCKETS];
	logic [CNT_W-1:0]   count_mem[NUM_BUCKETS];

	int error_count = 0;
	int events_seen = 0;
	int flushes_seen = 0;
	int queries_seen = 0;
	int ignored_seen = 0;
	int results_checked = 0;
	int input_stalls = 0;
	int drain_pauses = 0;

	windowed_event_rate_counter #(
		.BUCKETS(NUM_BUCKETS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_mode || r < 70) begin
			draw_gap = 0;
		end else if (r < 92) begin
			draw_gap = $urandom_range(1, 3);
		end else if (r < 98) begin
			draw_gap = $urandom_range(4, 12);
		end else begin
			draw_gap = $urandom_range(20, 60);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
			want);
		error_count++;
	endtask

	task automatic update_counters(input rate_item_t it);
		int unsigned slot;
		logic [63:0] sum;
		rate_stats_t stats;
		slot = it.now_second % NUM_BUCKETS;
		sum = '0;
		case (it.kind)
			KIND_EVENT: begin
				event_count_q = event_count_q + 1'b1;
				if (tag_mem[slot] == it.now_second) begin
					if (count_mem[slot] != CNT_MAX)
						count_mem[slot] = count_mem[slot] + 1'b1;
				end else begin
					tag_mem[slot] = it.now_second;
					count_mem[slot] = 1;
				end
				events_seen++;
			end
			KIND_FLUSH: begin
				flush_count_q = flush_count_q + 1'b1;
				flushes_seen++;
			end
			KIND_QUERY: begin
				for (int i = 0; i < NUM_BUCKETS; i++) begin
					if (tag_mem[i] <= it.now_second &&
							NOW_W'(it.now_second - tag_mem[i]) < NUM_BUCKETS)
						sum = sum + count_mem[i];
				end
				stats.total_events = event_count_q;
				stats.total_flushes = flush_count_q;
				stats.window_events = (sum > WIN_MAX) ? WIN_MAX : sum[WIN_W-1:0];
				stats_expected.insert(stats_expected.size(), stats);
				queries_seen++;
			end
			default: begin
				ignored_seen++;
			end
		endcase
	endtask

	task automatic check_stats(input logic [OUT_DATA_W-1:0] data);
		rate_stats_t want;
		if (stats_expected.size() == 0) begin
			report_mismatch("result with no query waiting, total_events", data[63:0], '0);
		end else begin
			want = stats_expected.pop_front();
			if (data[63:0] !== want.total_events)
				report_mismatch("total_events", data[63:0], want.total_events);
			if (data[127:64] !== want.total_flushes)
				report_mismatch("total_flushes", data[127:64], want.total_flushes);
			if (data[165:128] !== want.window_events)
				report_mismatch("window_events", data[165:128], want.window_events);
			results_checked++;
		end
	endtask

	task automatic add_item(input logic [KIND_W-1:0] kind, input logic [NOW_W-1:0] now_second,
			input logic wait_drain);
		rate_item_t it;
		it.kind = kind;
		it.now_second = now_second;
		it.wait_drain = wait_drain;
		item_queue.insert(item_queue.size(), it);
	endtask

	task automatic build_stimulus();
		logic [NOW_W-1:0] clock_now;
		logic             drain;
		int               r;
		int               n;
		// Fresh buckets, repeated seconds, slot reuse, window edges, 32-bit wrap,
		// a clock running backwards, the unused kind and a flush.
		add_item(KIND_QUERY, 32'd0, 1'b0);
		add_item(KIND_EVENT, 32'd0, 1'b0);
		add_item(KIND_EVENT, 32'd0, 1'b0);
		add_item(KIND_QUERY, 32'd0, 1'b0);
		add_item(KIND_FLUSH, 32'hFFFF_FFFF, 1'b0);
		add_item(KIND_UNUSED, 32'hFFFF_FFFF, 1'b0);
		add_item(KIND_EVENT, 32'd59, 1'b0);
		add_item(KIND_EVENT, 32'd60, 1'b0);
		add_item(KIND_QUERY, 32'd59, 1'b0);
		add_item(KIND_QUERY, 32'd119, 1'b0);
		add_item(KIND_QUERY, 32'd120, 1'b0);
		add_item(KIND_EVENT, 32'hFFFF_FFFF, 1'b0);
		add_item(KIND_EVENT, 32'hFFFF_FFFE, 1'b0);
		add_item(KIND_EVENT, 32'hFFFF_FFFF, 1'b0);
		add_item(KIND_QUERY, 32'hFFFF_FFFF, 1'b0);
		add_item(KIND_EVENT, 32'd5, 1'b0);
		add_item(KIND_QUERY, 32'd5, 1'b0);
		add_item(KIND_EVENT, 32'd1000, 1'b0);
		add_item(KIND_QUERY, 32'd999, 1'b0);
		add_item(KIND_FLUSH, 32'd0, 1'b0);
		add_item(KIND_QUERY, 32'hAAAA_AAAA, 1'b0);
		add_item(KIND_EVENT, 32'h5555_5555, 1'b0);
		add_item(KIND_QUERY, 32'h5555_5555, 1'b0);

		for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++) begin
			case (p)
				0: clock_now = $urandom_range(0, 40);
				1: clock_now = 32'hFFFF_FFFF - $urandom_range(0, 150);
				default: clock_now = $urandom();
			endcase
			drain = 1'b1;
			n = 0;
			while (n < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r >= 98)
					clock_now = clock_now + $urandom_range(71, 400);
				else if (r >= 95)
					clock_now = clock_now - $urandom_range(1, 10);
				else if (r >= 85)
					clock_now = clock_now + $urandom_range(2, 70);
				else if (r >= 55)
					clock_now = clock_now + 1'b1;
				r = $urandom_range(0, 99);
				if (r < 2) begin
					add_item(KIND_UNUSED, $urandom(), drain);
				end else begin
					if (r < 68) begin
						if ($urandom_range(0, 99) < 85)
							add_item(KIND_EVENT, clock_now, drain);
						else
							add_item(KIND_EVENT, clock_now - $urandom_range(1, 65), drain);
					end else if (r < 80) begin
						add_item(KIND_FLUSH, $urandom(), drain);
					end else begin
						if ($urandom_range(0, 99) < 70)
							add_item(KIND_QUERY, clock_now, drain);
						else
							add_item(KIND_QUERY, clock_now + $urandom_range(0, 70), drain);
					end
					n++;
				end
				drain = 1'b0;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (s_tvalid && s_tready) begin
				update_counters(cur_item);
				tx_busy = 1'b0;
				tx_gap = draw_gap();
			end else if (s_tvalid) begin
				input_stalls++;
			end
			if (m_tvalid && m_tready)
				check_stats(m_tdata);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (tx_busy) begin
		end else if (tx_gap > 0) begin
			s_tvalid <= 1'b0;
			tx_gap--;
		end else if (item_queue.size() == 0 ||
				(item_queue[0].wait_drain && stats_expected.size() != 0)) begin
			s_tvalid <= 1'b0;
		end else begin
			cur_item = item_queue.pop_front();
			if (cur_item.wait_drain)
				drain_pauses++;
			s_tdata <= cur_item.now_second;
			s_tuser <= cur_item.kind;
			s_tvalid <= 1'b1;
			tx_busy = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (cycle_count % QUIET_PERIOD == 0)
			quiet_mode = ($urandom_range(0, 3) == 0);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (cycle_count == HOLD_START_A || cycle_count == HOLD_START_B) begin
			m_tready <= 1'b0;
			hold_left = LONG_HOLD;
		end else if (rx_gap > 0) begin
			m_tready <= 1'b0;
			rx_gap--;
		end else begin
			m_tready <= 1'b1;
			rx_gap = draw_gap();
		end
	end

	initial begin
		event_count_q = '0;
		flush_count_q = '0;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			tag_mem[i] = '0;
			count_mem[i] = '0;
		end
		build_stimulus();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (!timed_out && (item_queue.size() != 0 || tx_busy || stats_expected.size() != 0))
				begin
			@(negedge clk);
			if (cycle_count >= CYCLE_LIMIT)
				timed_out = 1'b1;
		end
		if (!timed_out)
			repeat (TAIL_CYCLES) @(negedge clk);
		if (timed_out) begin
			$display("Timed out after %0d cycles.", cycle_count);
			$display("TEST FAILED");
		end else begin
			$display("Ran %0d events, %0d flushes, %0d queries and %0d unused-kind items.",
				events_seen, flushes_seen, queries_seen, ignored_seen);
			$display("Checked %0d results; input stalled %0d cycles; %0d drain pauses.",
				results_checked, input_stalls, drain_pauses);
			if (error_count == 0)
				$display("TEST PASSED");
			else
				$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/werc_pkg.sv
design/werc_front.sv
design/werc_fifo.sv
design/werc_back.sv
design/windowed_event_rate_counter.sv
design/werc_checker.sv
test/tb_windowed_event_rate_counter.sv
